// ===== hdl/gle_pkg.sv =====
package gle_pkg;

  localparam int HASH_SLOTS    = 5003;
  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_LIMIT   = 1 << MAX_CODE_BITS;
  localparam int SLOT_AW       = $clog2(HASH_SLOTS);
  localparam int PROBE_W       = $clog2(HASH_SLOTS + 1);
  localparam int EPOCH_W       = 6;
  localparam int ACC_W         = 20;
  localparam int BH_W          = 5;
  localparam int NFC_W         = MAX_CODE_BITS + 1;
  localparam int CW_W          = 4;
  localparam int CLR_W         = 9;

  typedef logic [SLOT_AW-1:0] slot_addr_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]       epoch;
    logic [MAX_CODE_BITS-1:0] code;
    logic [MAX_CODE_BITS-1:0] prefix;
    logic [7:0]               suffix;
  } slot_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_START,
    ST_START_PK,
    ST_HASH,
    ST_RD,
    ST_CHK,
    ST_MISS_PK,
    ST_INSERT,
    ST_FULL_PK,
    ST_POST,
    ST_LAST_PK,
    ST_END_PK,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

endpackage

// ===== hdl/gle_pix_if.sv =====
interface gle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_index;
  logic       last_pixel;
  modport source (output valid, output pixel_index, output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input last_pixel, output ready);
endinterface

// ===== hdl/gle_byte_if.sv =====
interface gle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;
  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

// ===== hdl/gle_cfg_if.sv =====
interface gle_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] min_code_size;
  modport source (output valid, output min_code_size, input ready);
  modport sink (input valid, input min_code_size, output ready);
endinterface

// ===== hdl/gle_slot_ram.sv =====
module gle_slot_ram (
  input  logic                clk,
  input  logic                wr_en,
  input  gle_pkg::slot_addr_t wr_addr,
  input  gle_pkg::slot_t      wr_data,
  input  gle_pkg::slot_addr_t rd_addr,
  output gle_pkg::slot_t      rd_data
);

  gle_pkg::slot_t mem [gle_pkg::HASH_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/gif_lzw_encoder_core.sv =====
// Channel | Dir | Payload                    | Accept
// in_ch   | in  | pixel_index, last_pixel    | valid & ready
// out_ch  | out | code_byte, last_byte       | valid & ready
// cfg_ch  | in  | min_code_size              | valid & ready (ready always high)
//
// A pixel on a first-probe hit passes accept, hash, read, compare and post;
// each extra hash probe adds one registered read of the slot RAM. A miss packs
// the pending code and sends its bytes; every other packed code (clear, pending,
// end) sends its bytes too, and the flush sends any partial last byte.
// After reset a sweep clears all 5003 slot RAM entries; the same sweep repeats
// once every 63 dictionary restarts when the epoch tag wraps.
// A stalled out_ch holds the byte register and the packer waits on it.
module gif_lzw_encoder_core (
  input logic        clk,
  input logic        rst_n,
  gle_pix_if.sink    in_ch,
  gle_byte_if.source out_ch,
  gle_cfg_if.sink    cfg_ch
);

  localparam int HS  = gle_pkg::HASH_SLOTS;
  localparam int AW  = gle_pkg::SLOT_AW;
  localparam int MCB = gle_pkg::MAX_CODE_BITS;

  gle_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [gle_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [gle_pkg::BH_W-1:0]    bh_r, bh_nxt;
  logic [gle_pkg::CW_W-1:0]    cw_r, cw_nxt;
  logic [gle_pkg::NFC_W-1:0]   nfc_r, nfc_nxt;
  logic [MCB-1:0]              pend_r, pend_nxt;
  logic [7:0]                  idx_r, idx_nxt;
  logic                        last_r, last_nxt;
  logic                        started_r, started_nxt;
  logic [AW-1:0]               k_r, k_nxt, disp_r, disp_nxt;
  logic [gle_pkg::PROBE_W-1:0] n_r, n_nxt;
  logic [gle_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]               sweep_r, sweep_nxt;
  logic [3:0]                  mcs_r;
  logic                        ov_r, ov_nxt;
  logic [7:0]                  ob_r, ob_nxt;
  logic                        ol_r, ol_nxt;

  logic [3:0]                  eff;
  logic [gle_pkg::CLR_W-1:0]   clr_code;
  logic                        do_pack;
  logic [MCB-1:0]              pk_code;
  logic [gle_pkg::ACC_W-1:0]   acc_pk;
  logic [gle_pkg::BH_W-1:0]    bh_pk;
  logic                        grow;
  logic [AW:0]                 hsum;
  logic                        out_free;
  logic                        wr_en;
  gle_pkg::slot_addr_t         wr_addr;
  gle_pkg::slot_t              wr_data, rd_data;

  gle_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (k_r),
    .rd_data (rd_data)
  );

  always_comb begin
    if (mcs_r < 4'd2) begin
      eff = 4'd2;
    end else if (mcs_r > 4'd8) begin
      eff = 4'd8;
    end else begin
      eff = mcs_r;
    end
  end

  assign clr_code = gle_pkg::CLR_W'(1) << eff;
  assign acc_pk     = acc_r | (gle_pkg::ACC_W'(pk_code) << bh_r);
  assign bh_pk      = bh_r + gle_pkg::BH_W'(cw_r);
  assign grow       = (nfc_r >= (gle_pkg::NFC_W'(1) << cw_r)) && (cw_r < gle_pkg::CW_W'(MCB));
  assign hsum       = (AW+1)'({idx_r, 4'b0000}) + (AW+1)'(pend_r);
  assign out_free   = !ov_r || out_ch.ready;

  assign in_ch.ready      = (state_r == gle_pkg::ST_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = ov_r;
  assign out_ch.code_byte = ob_r;
  assign out_ch.last_byte = ol_r;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    acc_nxt     = acc_r;
    bh_nxt      = bh_r;
    cw_nxt      = cw_r;
    nfc_nxt     = nfc_r;
    pend_nxt    = pend_r;
    idx_nxt     = idx_r;
    last_nxt    = last_r;
    started_nxt = started_r;
    k_nxt       = k_r;
    disp_nxt    = disp_r;
    n_nxt       = n_r;
    epoch_nxt   = epoch_r;
    sweep_nxt   = sweep_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    do_pack     = 1'b0;
    pk_code     = pend_r;
    wr_en       = 1'b0;
    wr_addr     = k_r;
    wr_data     = '{epoch: epoch_r, code: MCB'(nfc_r), prefix: pend_r, suffix: idx_r};

    case (state_r)
      gle_pkg::ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_r;
        wr_data = '0;
        if (sweep_r == AW'(HS - 1)) begin
          epoch_nxt = gle_pkg::EPOCH_W'(1);
          state_nxt = ret_r;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      gle_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          idx_nxt   = in_ch.pixel_index & 8'(clr_code - gle_pkg::CLR_W'(1));
          last_nxt  = in_ch.last_pixel;
          state_nxt = started_r ? gle_pkg::ST_HASH : gle_pkg::ST_START;
        end
      end
      gle_pkg::ST_START: begin
        nfc_nxt     = gle_pkg::NFC_W'(clr_code) + gle_pkg::NFC_W'(2);
        cw_nxt      = eff + 4'd1;
        acc_nxt     = '0;
        bh_nxt      = '0;
        pend_nxt    = MCB'(idx_r);
        started_nxt = 1'b1;
        if (epoch_r == '1) begin
          sweep_nxt = '0;
          ret_nxt   = gle_pkg::ST_START_PK;
          state_nxt = gle_pkg::ST_SWEEP;
        end else begin
          epoch_nxt = epoch_r + gle_pkg::EPOCH_W'(1);
          state_nxt = gle_pkg::ST_START_PK;
        end
      end
      gle_pkg::ST_START_PK: begin
        do_pack   = 1'b1;
        pk_code   = MCB'(clr_code);
        ret_nxt   = gle_pkg::ST_POST;
        state_nxt = gle_pkg::ST_DRAIN;
      end
      gle_pkg::ST_HASH: begin
        k_nxt     = (hsum >= (AW+1)'(HS)) ? AW'(hsum - (AW+1)'(HS)) : AW'(hsum);
        n_nxt     = '0;
        state_nxt = gle_pkg::ST_RD;
      end
      gle_pkg::ST_RD: begin
        if (n_r == '0) begin
          disp_nxt = (k_r != '0) ? AW'(HS) - k_r : AW'(1);
        end
        state_nxt = gle_pkg::ST_CHK;
      end
      gle_pkg::ST_CHK: begin
        if (rd_data.epoch != epoch_r) begin
          state_nxt = gle_pkg::ST_MISS_PK;
        end else if (rd_data.prefix == pend_r && rd_data.suffix == idx_r) begin
          pend_nxt  = rd_data.code;
          state_nxt = gle_pkg::ST_POST;
        end else if (n_r == gle_pkg::PROBE_W'(HS)) begin
          state_nxt = gle_pkg::ST_MISS_PK;
        end else begin
          k_nxt     = (k_r >= disp_r) ? k_r - disp_r : k_r + AW'(HS) - disp_r;
          n_nxt     = n_r + gle_pkg::PROBE_W'(1);
          state_nxt = gle_pkg::ST_RD;
        end
      end
      gle_pkg::ST_MISS_PK: begin
        do_pack   = 1'b1;
        pk_code   = pend_r;
        ret_nxt   = gle_pkg::ST_INSERT;
        state_nxt = gle_pkg::ST_DRAIN;
      end
      gle_pkg::ST_INSERT: begin
        pend_nxt = MCB'(idx_r);
        if (nfc_r < gle_pkg::NFC_W'(gle_pkg::TABLE_LIMIT)) begin
          wr_en     = 1'b1;
          nfc_nxt   = nfc_r + gle_pkg::NFC_W'(1);
          state_nxt = gle_pkg::ST_POST;
        end else begin
          nfc_nxt = gle_pkg::NFC_W'(clr_code) + gle_pkg::NFC_W'(2);
          if (epoch_r == '1) begin
            sweep_nxt = '0;
            ret_nxt   = gle_pkg::ST_FULL_PK;
            state_nxt = gle_pkg::ST_SWEEP;
          end else begin
            epoch_nxt = epoch_r + gle_pkg::EPOCH_W'(1);
            state_nxt = gle_pkg::ST_FULL_PK;
          end
        end
      end
      gle_pkg::ST_FULL_PK: begin
        do_pack   = 1'b1;
        pk_code   = MCB'(clr_code);
        ret_nxt   = gle_pkg::ST_POST;
        state_nxt = gle_pkg::ST_DRAIN;
      end
      gle_pkg::ST_POST: begin
        state_nxt = last_r ? gle_pkg::ST_LAST_PK : gle_pkg::ST_IDLE;
      end
      gle_pkg::ST_LAST_PK: begin
        do_pack   = 1'b1;
        pk_code   = pend_r;
        ret_nxt   = gle_pkg::ST_END_PK;
        state_nxt = gle_pkg::ST_DRAIN;
      end
      gle_pkg::ST_END_PK: begin
        do_pack   = 1'b1;
        pk_code   = MCB'(clr_code) + MCB'(1);
        ret_nxt   = gle_pkg::ST_FLUSH;
        state_nxt = gle_pkg::ST_DRAIN;
      end
      gle_pkg::ST_FLUSH: begin
        if (bh_r == '0 || out_free) begin
          if (bh_r != '0) begin
            ov_nxt = 1'b1;
            ob_nxt = acc_r[7:0];
            ol_nxt = 1'b1;
          end
          started_nxt = 1'b0;
          acc_nxt     = '0;
          bh_nxt      = '0;
          state_nxt   = gle_pkg::ST_IDLE;
        end
      end
      gle_pkg::ST_DRAIN: begin
        if (bh_r >= gle_pkg::BH_W'(8)) begin
          if (out_free) begin
            ov_nxt  = 1'b1;
            ob_nxt  = acc_r[7:0];
            ol_nxt  = (ret_r == gle_pkg::ST_FLUSH) && (bh_r == gle_pkg::BH_W'(8));
            acc_nxt = acc_r >> 8;
            bh_nxt  = bh_r - gle_pkg::BH_W'(8);
          end
        end else begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = gle_pkg::ST_IDLE;
      end
    endcase

    if (do_pack) begin
      acc_nxt = acc_pk;
      bh_nxt  = bh_pk;
      if (state_r == gle_pkg::ST_FULL_PK) begin
        cw_nxt = eff + 4'd1;
      end else if (grow) begin
        cw_nxt = cw_r + gle_pkg::CW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gle_pkg::ST_SWEEP;
      ret_r     <= gle_pkg::ST_IDLE;
      acc_r     <= '0;
      bh_r      <= '0;
      cw_r      <= 4'd9;
      nfc_r     <= gle_pkg::NFC_W'(258);
      pend_r    <= '0;
      started_r <= 1'b0;
      epoch_r   <= gle_pkg::EPOCH_W'(1);
      sweep_r   <= '0;
      mcs_r     <= 4'd8;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      acc_r     <= acc_nxt;
      bh_r      <= bh_nxt;
      cw_r      <= cw_nxt;
      nfc_r     <= nfc_nxt;
      pend_r    <= pend_nxt;
      started_r <= started_nxt;
      epoch_r   <= epoch_nxt;
      sweep_r   <= sweep_nxt;
      ov_r      <= ov_nxt;
      if (cfg_ch.valid && !started_r) begin
        mcs_r <= cfg_ch.min_code_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    disp_r <= disp_nxt;
    n_r    <= n_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

endmodule

// ===== hdl/gle_checker.sv =====
module gle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_code_byte,
  input logic       out_last_byte,
  input logic       cfg_ready
);

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after an item");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_byte) && $stable(out_last_byte))
    else $error("stalled output item changed");

  a_no_reset_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gif_lzw_encoder_core gle_checker u_gle_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_code_byte (out_ch.code_byte),
  .out_last_byte (out_ch.last_byte),
  .cfg_ready     (cfg_ch.ready)
);
